### design/ihss_pkg.sv
// ----------------------------------------------------------------------------
// Image header size sniffer package
// Format codes, header positions and the result type shared by the block.
// ----------------------------------------------------------------------------
package ihss_pkg;

    localparam logic [1:0] KIND_PNG  = 2'd0;
    localparam logic [1:0] KIND_JPEG = 2'd1;
    localparam logic [1:0] KIND_BMP  = 2'd2;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOF0 = 8'hC0;
    localparam logic [7:0] BYTE_SOF2 = 8'hC2;

    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_J = 8'h4A;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_I = 8'h49;

    localparam int HDR_FIRST   = 16;
    localparam int HDR_BYTES   = 8;
    localparam int HDR_END     = 24;
    localparam int PNG_MIN     = 4;
    localparam int JFIF_MIN    = 10;
    localparam int MARKER_MIN  = 5;

    localparam logic [3:0] MCNT_START = 4'd2;
    localparam logic [3:0] MCNT_FIRST = 4'd5;
    localparam logic [3:0] MCNT_LAST  = 4'd8;

    typedef struct packed {
        logic [1:0]  image_kind;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic        size_found;
    } t_result;

endpackage

### design/ihss_if.sv
// ----------------------------------------------------------------------------
// Image header size sniffer channels
// Valid/ready channels for the byte stream and for the size result.
// ----------------------------------------------------------------------------
interface ihss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihss_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  image_kind;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        size_found;

    modport source (output valid, output image_kind, output image_width,
                    output image_height, output size_found, input ready);
    modport sink   (input valid, input image_kind, input image_width,
                    input image_height, input size_found, output ready);
endinterface

### design/image_header_size_sniffer.sv
// ----------------------------------------------------------------------------
// Image header size sniffer
// Classifies a PNG, JPEG or BMP byte stream and reports its pixel size.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle, except that the byte flagged as
// the last of a file waits in the input register while the result queue
// is full. The result beat then enters the result queue. A two-entry result
// queue lets the next file stream in while a result is waiting to be taken.
module image_header_size_sniffer #(
    parameter int OFFSET_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_wr_en,
    input  logic   i_cfg_wr_data,
    ihss_byte_if.sink     i_byte,
    ihss_result_if.source o_result
);
    import ihss_pkg::*;

    logic    r_accept_progressive;
    logic    push;
    logic    push_ok;
    t_result parse_result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_progressive <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_accept_progressive <= i_cfg_wr_data;
        end
    end

    ihss_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept_progressive(r_accept_progressive),
        .i_valid             (i_byte.valid),
        .o_ready             (i_byte.ready),
        .i_data_byte         (i_byte.data_byte),
        .i_last_byte         (i_byte.last_byte),
        .i_push_ok           (push_ok),
        .o_push              (push),
        .o_result            (parse_result)
    );

    ihss_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parse_result),
        .o_push_ok(push_ok),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (out_result)
    );

    assign o_result.image_kind   = out_result.image_kind;
    assign o_result.image_width  = out_result.image_width;
    assign o_result.image_height = out_result.image_height;
    assign o_result.size_found   = out_result.size_found;

endmodule

### design/ihss_parser.sv
// ----------------------------------------------------------------------------
// Image header size sniffer parser
// Input register, per-file parse state and result formation for each beat.
// ----------------------------------------------------------------------------
module ihss_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept_progressive,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_push_ok,
    output logic             o_push,
    output ihss_pkg::t_result o_result
);
    import ihss_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;

    logic [OFFSET_BITS-1:0] r_offset,  n_offset;
    logic                   r_png_ok,  n_png_ok;
    logic                   r_jfif_ok, n_jfif_ok;
    logic [7:0]             r_hdr  [HDR_BYTES];
    logic [7:0]             n_hdr  [HDR_BYTES];
    logic                   r_prev_ff, n_prev_ff;
    logic                   r_mseen,   n_mseen;
    logic [3:0]             r_mcnt,    n_mcnt;
    logic [7:0]             r_dim  [4];
    logic [7:0]             n_dim  [4];

    logic fire;
    logic [7:0] b;

    assign b       = r_in_byte;
    assign fire    = r_in_valid && (!r_in_last || i_push_ok);
    assign o_ready = !r_in_valid || fire;
    assign o_push  = fire && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_comb begin
        n_png_ok  = r_png_ok;
        n_jfif_ok = r_jfif_ok;
        if (r_offset == OFFSET_BITS'(1) && b != CHAR_P) n_png_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(2) && b != CHAR_N) n_png_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(3) && b != CHAR_G) n_png_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(6) && b != CHAR_J) n_jfif_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(7) && b != CHAR_F) n_jfif_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(8) && b != CHAR_I) n_jfif_ok = 1'b0;
        if (r_offset == OFFSET_BITS'(9) && b != CHAR_F) n_jfif_ok = 1'b0;

        for (int k = 0; k < HDR_BYTES; k++) begin
            n_hdr[k] = (r_offset == OFFSET_BITS'(HDR_FIRST + k)) ? (r_hdr[k] | b) : r_hdr[k];
        end

        n_mseen = r_mseen;
        n_mcnt  = r_mcnt;
        for (int k = 0; k < 4; k++) begin
            n_dim[k] = r_dim[k];
        end
        if (r_mseen) begin
            if (r_mcnt <= MCNT_LAST) begin
                if (r_mcnt >= MCNT_FIRST) begin
                    n_dim[2'(r_mcnt - MCNT_FIRST)] = r_dim[2'(r_mcnt - MCNT_FIRST)] | b;
                end
                n_mcnt = r_mcnt + 4'd1;
            end
        end else if (r_prev_ff &&
                     (b == BYTE_SOF0 || (b == BYTE_SOF2 && i_accept_progressive))) begin
            n_mseen = 1'b1;
            n_mcnt  = MCNT_START;
        end
        n_prev_ff = (b == BYTE_FF) && (r_offset >= OFFSET_BITS'(MARKER_MIN));

        n_offset = (r_offset == '1) ? r_offset : r_offset + OFFSET_BITS'(1);
    end

    always_comb begin
        if (n_png_ok && n_offset >= OFFSET_BITS'(PNG_MIN)) begin
            o_result.image_kind   = KIND_PNG;
            o_result.image_width  = {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]};
            o_result.image_height = {n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]};
            o_result.size_found   = (n_offset >= OFFSET_BITS'(HDR_END));
        end else if (n_jfif_ok && n_offset >= OFFSET_BITS'(JFIF_MIN)) begin
            o_result.image_kind   = KIND_JPEG;
            o_result.image_width  = {16'd0, n_dim[2], n_dim[3]};
            o_result.image_height = {16'd0, n_dim[0], n_dim[1]};
            o_result.size_found   = n_mseen;
        end else begin
            o_result.image_kind   = KIND_BMP;
            o_result.image_width  = {16'd0, n_hdr[3], n_hdr[2]};
            o_result.image_height = {16'd0, n_hdr[7], n_hdr[6]};
            o_result.size_found   = (n_offset >= OFFSET_BITS'(HDR_END));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_offset  <= '0;
            r_png_ok  <= 1'b1;
            r_jfif_ok <= 1'b1;
            r_prev_ff <= 1'b0;
            r_mseen   <= 1'b0;
            r_mcnt    <= '0;
            for (int k = 0; k < HDR_BYTES; k++) begin
                r_hdr[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_dim[k] <= '0;
            end
        end else if (fire) begin
            r_offset  <= n_offset;
            r_png_ok  <= n_png_ok;
            r_jfif_ok <= n_jfif_ok;
            r_prev_ff <= n_prev_ff;
            r_mseen   <= n_mseen;
            r_mcnt    <= n_mcnt;
            for (int k = 0; k < HDR_BYTES; k++) begin
                r_hdr[k] <= n_hdr[k];
            end
            for (int k = 0; k < 4; k++) begin
                r_dim[k] <= n_dim[k];
            end
        end
    end

endmodule

### design/ihss_out_queue.sv
// ----------------------------------------------------------------------------
// Image header size sniffer output queue
// Result register with one skid entry so parsing continues while a beat waits.
// ----------------------------------------------------------------------------
module ihss_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihss_pkg::t_result i_result,
    output logic              o_push_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output ihss_pkg::t_result o_result
);
    import ihss_pkg::*;

    logic    r_head_valid;
    logic    r_skid_valid;
    t_result r_head;
    t_result r_skid;
    logic    pop;

    assign pop       = r_head_valid && i_ready;
    assign o_push_ok = !r_skid_valid;
    assign o_valid   = r_head_valid;
    assign o_result  = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_head       <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_head <= i_result;
            end else begin
                r_head_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                r_head       <= i_result;
                r_head_valid <= 1'b1;
            end else begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

### design/ihss_checker.sv
// ----------------------------------------------------------------------------
// Image header size sniffer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ihss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_image_kind,
    input logic [31:0] i_image_width,
    input logic [31:0] i_image_height,
    input logic        i_size_found
);
    import ihss_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && !i_out_ready) |->
            (i_out_valid && $stable(i_image_kind) && $stable(i_image_width) &&
             $stable(i_image_height) && $stable(i_size_found)))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_jpeg_no_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_image_kind == KIND_JPEG && !i_size_found) |->
            (i_image_width == 32'd0 && i_image_height == 32'd0))
        else $error("JPEG size given without a frame marker");

    a_narrow_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_image_kind == KIND_BMP || i_image_kind == KIND_JPEG)) |->
            (i_image_width[31:16] == 16'd0 && i_image_height[31:16] == 16'd0))
        else $error("16-bit size format gave a wide value");

endmodule

bind image_header_size_sniffer ihss_checker u_ihss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_image_kind  (o_result.image_kind),
    .i_image_width (o_result.image_width),
    .i_image_height(o_result.image_height),
    .i_size_found  (o_result.size_found)
);
